>>> design/totp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// totp_pkg
// shared types and constants of the time-based one-time code generator
// ---------------------------------------------------------------------------
package totp_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;   // word 0 is the first word of the block
	typedef logic [4:0][31:0] hash_t;     // word 0 is h0

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 64;

	localparam logic [CfgAddrW-1:0] REG_KEY0   = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_KEY1   = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_KEY2   = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_KEY3   = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_KEYLEN = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_DIGITS = 3'd5;
	localparam logic [CfgAddrW-1:0] REG_PERIOD = 3'd6;

	localparam hash_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam word_t IPAD_WORD = 32'h36363636;
	localparam word_t OPAD_WORD = 32'h5C5C5C5C;
	localparam word_t PAD_START = 32'h80000000;
	localparam word_t INNER_BITS = 32'd576;   // (64 + 8) bytes
	localparam word_t OUTER_BITS = 32'd672;   // (64 + 20) bytes
	localparam logic [30:0] BIN_MASK = 31'h7fffffff;

	// ten to the clamped digit count
	function automatic logic [29:0] pow10(input logic [3:0] digits);
		logic [29:0] r;
		case (digits)
			4'd0, 4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/totp_sha1_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// totp_sha1_core
// one sha-1 compression, one round per cycle over a 16-word schedule window
// ---------------------------------------------------------------------------
module totp_sha1_core
	import totp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire block_t blk,
	input  wire hash_t  h_in,
	output logic        busy,
	output logic        done,
	output hash_t       h_out
);

	logic         busy_q;
	logic         fin_q;
	logic [6:0]   round_q;
	logic [15:0][31:0] w_q;
	word_t        a_q, b_q, c_q, d_q, e_q;
	hash_t        hsave_q;
	hash_t        hout_q;
	logic         done_q;

	word_t f, k, t, wnext;

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wnext = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wnext = {wnext[30:0], wnext[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q  <= 1'b1;
				fin_q   <= 1'b0;
				round_q <= '0;
			end else if (busy_q && !fin_q) begin
				if (round_q == 7'd79) fin_q <= 1'b1;
				round_q <= round_q + 7'd1;
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			w_q     <= blk;
			a_q     <= h_in[0];
			b_q     <= h_in[1];
			c_q     <= h_in[2];
			d_q     <= h_in[3];
			e_q     <= h_in[4];
			hsave_q <= h_in;
		end else if (busy_q && !fin_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnext;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end else if (fin_q) begin
			hout_q[0] <= hsave_q[0] + a_q;
			hout_q[1] <= hsave_q[1] + b_q;
			hout_q[2] <= hsave_q[2] + c_q;
			hout_q[3] <= hsave_q[3] + d_q;
			hout_q[4] <= hsave_q[4] + e_q;
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign h_out = hout_q;

endmodule

`default_nettype wire

>>> design/totp_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// totp_divider
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// ---------------------------------------------------------------------------
module totp_divider
	import totp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [63:0]      quotient,
	output logic [31:0]      remainder
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] q_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;

	logic [32:0] trial;
	logic        fits;

	always_comb begin
		trial = {rem_q, q_q[63]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			q_q   <= {q_q[62:0], fits};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> design/totp_code_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// totp_code_generator_top
// hmac-sha1 time-based one-time code generator with a shared sha-1 round unit
// ---------------------------------------------------------------------------
// usage:
//   s_* channel takes one request word: tdata = unix_time[62:0], step_offset[71:63],
//   tuser = kind. kind 0 gives one code at step + offset, kind 1 gives three
//   codes for steps -1, 0, +1 with tlast on the third.
//   m_* channel gives result words: tdata = code[29:0], window_position[31:30].
//   cfg_we/cfg_addr/cfg_data write the key, key length, digits and period; the user
//   must write them only while no request is in flight, the block has no check for it.
// sequence:
//   the time divide runs once per request; each code then runs four sha-1
//   compressions on one round unit and a modulo on the shared divider, and
//   then loads the output register. s_tready is high only while idle.
// reset clears the registers to key 0, length 0, 6 digits, period 30.
// a stalled receiver holds the result word; the sequencer waits before
// loading the next code until the output register is free.
// ---------------------------------------------------------------------------
module totp_code_generator_top
	import totp_pkg::*;
#(
	parameter int KEY_BYTES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [71:0]         s_tdata,   // unix_time[62:0], step_offset[71:63]
	input  wire logic                s_tuser,   // kind
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [31:0]              m_tdata,   // code[29:0], window_position[31:30]
	output logic                     m_tlast,
	input  wire logic                cfg_we,
	input  wire logic [CfgAddrW-1:0] cfg_addr,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	localparam int KeyMax = (KEY_BYTES < 32) ? KEY_BYTES : 32;

	typedef enum logic [2:0] {
		S_IDLE, S_DIVT, S_I1, S_I2, S_O1, S_O2, S_MOD, S_OUT
	} state_t;

	state_t      state_q;
	logic [3:0][63:0] key_q;
	logic [5:0]  klen_q;
	logic [3:0]  digits_q;
	logic [15:0] period_q;

	logic        kind_q;
	logic [62:0] time_q;
	logic [8:0]  offs_q;
	logic [63:0] step_q;
	logic [1:0]  pos_q;
	logic [29:0] code_q;
	hash_t       hmid_q;
	hash_t       inner_q;
	logic        sha_start_q;
	logic        div_start_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tlast_q;

	logic        sha_busy, sha_done, div_busy, div_done;
	hash_t       sha_out;
	logic [63:0] div_quot;
	logic [31:0] div_rem;
	block_t      sha_blk;
	hash_t       sha_h;
	logic [63:0] div_dvd;
	logic [31:0] div_dvs;

	logic [5:0]  klen_eff;
	logic [7:0][31:0] kword;
	logic [63:0] code_step;
	logic [63:0] delta;
	logic [159:0] macv;
	logic [159:0] mac_sh;
	logic [30:0] bin;
	logic        out_free;
	logic        is_last;

	// key block, bytes at or beyond the clamped length read as zero
	always_comb begin
		klen_eff = (klen_q > 6'(KeyMax)) ? 6'(KeyMax) : klen_q;
		for (int i = 0; i < 32; i++) begin
			kword[i/4][8*(3-(i%4)) +: 8] = (6'(i) < klen_eff) ?
				key_q[i/8][8*(7-(i%8)) +: 8] : 8'h00;
		end
	end

	always_comb begin
		if (kind_q) delta = 64'(pos_q) - 64'd1;
		else        delta = {{55{offs_q[8]}}, offs_q};
		code_step = step_q + delta;
	end

	always_comb begin
		sha_blk = '0;
		sha_h   = SHA1_IV;
		case (state_q)
			S_I1: begin
				for (int j = 0; j < 8; j++) sha_blk[j] = kword[j] ^ IPAD_WORD;
				for (int j = 8; j < 16; j++) sha_blk[j] = IPAD_WORD;
			end
			S_I2: begin
				sha_blk[0]  = code_step[63:32];
				sha_blk[1]  = code_step[31:0];
				sha_blk[2]  = PAD_START;
				sha_blk[15] = INNER_BITS;
				sha_h       = hmid_q;
			end
			S_O1: begin
				for (int j = 0; j < 8; j++) sha_blk[j] = kword[j] ^ OPAD_WORD;
				for (int j = 8; j < 16; j++) sha_blk[j] = OPAD_WORD;
			end
			S_O2: begin
				for (int j = 0; j < 5; j++) sha_blk[j] = inner_q[j];
				sha_blk[5]  = PAD_START;
				sha_blk[15] = OUTER_BITS;
				sha_h       = hmid_q;
			end
			default: begin
				sha_blk = '0;
			end
		endcase
	end

	// dynamic truncation on the final mac
	always_comb begin
		macv   = {sha_out[0], sha_out[1], sha_out[2], sha_out[3], sha_out[4]};
		mac_sh = macv << {sha_out[4][3:0], 3'b000};
		bin    = mac_sh[158:128] & BIN_MASK;
	end

	always_comb begin
		if (state_q == S_DIVT) begin
			div_dvd = {1'b0, time_q};
			div_dvs = {16'd0, (period_q == 16'd0) ? 16'd1 : period_q};
		end else begin
			div_dvd = {33'd0, bin};
			div_dvs = {2'b00, pow10(digits_q)};
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign is_last  = !kind_q || (pos_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			klen_q   <= '0;
			digits_q <= 4'd6;
			period_q <= 16'd30;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEY0:   key_q[0] <= cfg_data;
				REG_KEY1:   key_q[1] <= cfg_data;
				REG_KEY2:   key_q[2] <= cfg_data;
				REG_KEY3:   key_q[3] <= cfg_data;
				REG_KEYLEN: klen_q   <= cfg_data[5:0];
				REG_DIGITS: digits_q <= cfg_data[3:0];
				REG_PERIOD: period_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sha_start_q <= 1'b0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			kind_q      <= 1'b0;
			pos_q       <= '0;
		end else begin
			sha_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q      <= s_tuser;
						time_q      <= s_tdata[62:0];
						offs_q      <= s_tdata[71:63];
						pos_q       <= s_tuser ? 2'd0 : 2'd1;
						div_start_q <= 1'b1;
						state_q     <= S_DIVT;
					end
				end
				S_DIVT: begin
					if (div_done) begin
						step_q      <= div_quot;
						sha_start_q <= 1'b1;
						state_q     <= S_I1;
					end
				end
				S_I1: begin
					if (sha_done) begin
						hmid_q      <= sha_out;
						sha_start_q <= 1'b1;
						state_q     <= S_I2;
					end
				end
				S_I2: begin
					if (sha_done) begin
						inner_q     <= sha_out;
						sha_start_q <= 1'b1;
						state_q     <= S_O1;
					end
				end
				S_O1: begin
					if (sha_done) begin
						hmid_q      <= sha_out;
						sha_start_q <= 1'b1;
						state_q     <= S_O2;
					end
				end
				S_O2: begin
					if (sha_done) begin
						div_start_q <= 1'b1;
						state_q     <= S_MOD;
					end
				end
				S_MOD: begin
					if (div_done) begin
						code_q  <= div_rem[29:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {pos_q, code_q};
						m_tlast_q  <= is_last;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							pos_q       <= pos_q + 2'd1;
							sha_start_q <= 1'b1;
							state_q     <= S_I1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	totp_sha1_core u_sha1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start_q),
		.blk    (sha_blk),
		.h_in   (sha_h),
		.busy   (sha_busy),
		.done   (sha_done),
		.h_out  (sha_out)
	);

	totp_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_sha_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sha_done |-> (state_q == S_I1 || state_q == S_I2 || state_q == S_O1 ||
			state_q == S_O2))
		else $error("sha done outside a hash phase");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVT || state_q == S_MOD))
		else $error("divider done outside a divide phase");
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sha_busy && div_busy))
		else $error("sha unit and divider busy together");
	a_pos2_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:30] == 2'd2 |-> m_tlast)
		else $error("next-step code not marked last");
`endif

endmodule

`default_nettype wire

>>> tb/sv/totp_code_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// totp_code_checker
// watches the request and code channels of the one-time code generator,
// computes the expected hmac-sha1 codes and compares every code word
// ---------------------------------------------------------------------------
module totp_code_checker
	import totp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [71:0]         s_tdata,
	input  wire logic                s_tuser,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [31:0]         m_tdata,
	input  wire logic                m_tlast,
	input  wire logic                cfg_we,
	input  wire logic [CfgAddrW-1:0] cfg_addr,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output int                       fail_count,
	output int                       codes_pending
);

	typedef struct packed {
		logic [29:0] code;
		logic [1:0]  position;
		logic        last;
	} code_word_t;

	logic [63:0] key_words [4];
	logic [5:0]  key_len;
	logic [3:0]  digits;
	logic [15:0] period;
	code_word_t  expected_codes [$];

	assign codes_pending = expected_codes.size();

	function automatic void queue_code(input code_word_t cw);
		expected_codes = {expected_codes, cw};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress(inout logic [31:0] h [5], input logic [7:0] blk [64]);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
	endfunction

	// padded key block xor pad, then a tail of n bytes
	function automatic void keyed_hash(input logic [7:0] pad, input logic [7:0] tail [20],
			input int n, output logic [7:0] digest [20]);
		logic [31:0] h [5];
		logic [7:0]  blk [64];
		logic [63:0] bits;
		int          len;
		h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
		len = (key_len > 6'd32) ? 32 : int'(key_len);
		for (int i = 0; i < 64; i++)
			blk[i] = ((i < len) ? key_words[i/8][8*(7-i%8) +: 8] : 8'h00) ^ pad;
		compress(h, blk);
		bits = 64'((64 + n) * 8);
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		for (int i = 0; i < n; i++) blk[i] = tail[i];
		blk[n] = 8'h80;
		for (int i = 0; i < 8; i++) blk[56+i] = bits[8*(7-i) +: 8];
		compress(h, blk);
		for (int i = 0; i < 20; i++) digest[i] = h[i/4][8*(3-i%4) +: 8];
	endfunction

	function automatic logic [29:0] otp_code(input logic [63:0] step);
		logic [7:0]  msg [20];
		logic [7:0]  inner [20];
		logic [7:0]  mac [20];
		logic [31:0] bin, modulus;
		int          off, nd;
		for (int i = 0; i < 20; i++) msg[i] = (i < 8) ? step[8*(7-i) +: 8] : 8'h00;
		keyed_hash(8'h36, msg, 8, inner);
		keyed_hash(8'h5C, inner, 20, mac);
		off = int'(mac[19] & 8'h0F);
		bin = {mac[off], mac[off+1], mac[off+2], mac[off+3]} & 32'h7fffffff;
		nd = (digits < 4'd1) ? 1 : ((digits > 4'd9) ? 9 : int'(digits));
		modulus = 1;
		for (int i = 0; i < nd; i++) modulus *= 10;
		return 30'(bin % modulus);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] step;
		logic [63:0] offs;
		code_word_t  got, want;
		int          errs;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_words[i] <= '0;
			key_len <= '0;
			digits <= 4'd6;
			period <= 16'd30;
			fail_count <= 0;
			expected_codes.delete();
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_addr)
					REG_KEY0:   key_words[0] <= cfg_data;
					REG_KEY1:   key_words[1] <= cfg_data;
					REG_KEY2:   key_words[2] <= cfg_data;
					REG_KEY3:   key_words[3] <= cfg_data;
					REG_KEYLEN: key_len <= cfg_data[5:0];
					REG_DIGITS: digits <= cfg_data[3:0];
					REG_PERIOD: period <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				step = {1'b0, s_tdata[62:0]} / ((period == 0) ? 64'd1 : {48'd0, period});
				if (!s_tuser) begin
					offs = {{55{s_tdata[71]}}, s_tdata[71:63]};
					queue_code('{otp_code(step + offs), 2'd1, 1'b1});
				end else begin
					for (int k = 0; k < 3; k++)
						queue_code('{otp_code(step + k - 1), k[1:0], k == 2});
				end
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[29:0], m_tdata[31:30], m_tlast};
				if (expected_codes.size() == 0) begin
					$error("code word with none expected: %h", m_tdata);
					errs++;
				end else begin
					want = expected_codes.pop_front();
					if (got.code !== want.code) begin
						$error("code: expected %0d, actual %0d", want.code, got.code);
						errs++;
					end
					if (got.position !== want.position) begin
						$error("window_position: expected %0d, actual %0d",
							want.position, got.position);
						errs++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, got.last);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end

endmodule

>>> tb/sv/totp_code_generator_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// totp_code_generator_top_tb
// drives time requests under several key, digit and period settings with
// bursty requests and a stalling code receiver; the checker predicts codes
// ---------------------------------------------------------------------------
module totp_code_generator_top_tb;
	import totp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [71:0]         s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [31:0]         m_tdata;
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	int                  fail_count;
	int                  codes_pending;
	int                  idle_cycles = 0;
	int                  burst_left = 0;

	always #2 clk = ~clk;

	totp_code_generator_top DUT (.*);
	totp_code_checker checker_inst (.*);

	// receiver stall pattern: long ready stretches, bursts of stalls
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) m_tready <= 1'b0;
		else if (r < 50) m_tready <= m_tready;
		else m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (codes_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic configure(input int key_len, input int nd, input int per);
		for (int i = 0; i < 4; i++)
			write_reg(CfgAddrW'(REG_KEY0 + i), {$urandom, $urandom});
		write_reg(REG_KEYLEN, 64'(key_len));
		write_reg(REG_DIGITS, 64'(nd));
		write_reg(REG_PERIOD, 64'(per));
		cfg_we <= 1'b0;
	endtask

	// valid stays high between words of a burst, drops only for a gap
	task automatic send_request(input logic kind, input logic [62:0] t, input logic [8:0] offs);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 6);
			gap = $urandom_range(0, 3) * $urandom_range(0, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {offs, t};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [62:0] rand_time();
		logic [62:0] t;
		t = 63'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: t = 63'(t[31:0]);
			1: t = 63'($urandom_range(0, 1000));
			default: ;
		endcase
		return t;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: reset settings, extreme times and offsets
		send_request(1'b0, '0, 9'h000);
		send_request(1'b0, '0, 9'h100);
		send_request(1'b1, '0, 9'h000);
		send_request(1'b0, '1, 9'h0FF);
		send_request(1'b1, '1, 9'h1FF);
		send_request(1'b0, 63'd59, 9'h1FF);
		drain();
		// full key, max digits, period one: largest step and step wrap below zero
		configure(32, 9, 1);
		send_request(1'b0, '1, 9'h001);
		send_request(1'b1, '0, 9'h0AA);
		send_request(1'b0, 63'd5, 9'h100);
		drain();
		// oversized length, zero digits, zero period
		configure(63, 0, 0);
		send_request(1'b0, 63'd1234567, 9'h055);
		send_request(1'b1, '1, 9'h000);
		drain();
		// digits above nine, largest period
		configure(1, 15, 65535);
		send_request(1'b0, '1, 9'h1FF);
		send_request(1'b1, 63'd65535, 9'h000);
		drain();
		configure(20, 1, 30);
		send_request(1'b0, 63'd1111111109, 9'h000);
		send_request(1'b1, 63'd2000000000, 9'h000);
		drain();
		// random phases with random settings
		for (int phase = 0; phase < 10; phase++) begin
			configure($urandom_range(0, 63), $urandom_range(0, 15),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 60));
			for (int i = 0; i < 44; i++)
				send_request(1'($urandom), rand_time(), 9'($urandom));
			drain();
		end
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
design/totp_pkg.sv
design/totp_sha1_core.sv
design/totp_divider.sv
design/totp_code_generator_top.sv
tb/sv/totp_code_checker.sv
tb/sv/totp_code_generator_top_tb.sv
